[design/bced_pkg.sv]
// Shared types and constants for the button click event detector.
// Holds the configuration bundle, the stage encoding and the event codes.
// No dependencies.
package bced_pkg;

	// Millisecond counter width and its saturation value.
	localparam int unsigned CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Configuration register widths and indexes.
	localparam int unsigned THR_W = 16;
	localparam int unsigned TICK_W = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [THR_W-1:0] LONG_THR_RST = 16'd1000;
	localparam logic [THR_W-1:0] DOUBLE_THR_RST = 16'd300;
	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 10'd10;

	// Event codes reported per tick.
	localparam int unsigned EV_W = 2;
	localparam logic [EV_W-1:0] EV_NONE = 2'd0;
	localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
	localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EV_W-1:0] EV_LONG = 2'd3;

	// Current configuration as seen by the classifier.
	typedef struct packed {
		logic [THR_W-1:0]  long_thr;
		logic [THR_W-1:0]  double_thr;
		logic [TICK_W-1:0] tick_period;
	} cfg_t;

	// Classifier stages, one-hot.
	typedef enum logic [5:0] {
		ST_WAIT     = 6'b000001,
		ST_DEBOUNCE = 6'b000010,
		ST_HOLD     = 6'b000100,
		ST_GAP      = 6'b001000,
		ST_RELEASE  = 6'b010000,
		ST_REPEAT   = 6'b100000
	} stage_t;

endpackage

[design/bced_cfg.sv]
// Configuration register file for the button click event detector.
// Depends on bced_pkg for widths, register indexes and reset values.
module bced_cfg import bced_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [THR_W-1:0]  long_thr_q;
	logic [THR_W-1:0]  double_thr_q;
	logic [TICK_W-1:0] tick_period_q;

	// Write one register per enabled cycle; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_thr_q    <= LONG_THR_RST;
			double_thr_q  <= DOUBLE_THR_RST;
			tick_period_q <= TICK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_THR:    long_thr_q <= cfg_data[THR_W-1:0];
				REG_DOUBLE_THR:  double_thr_q <= cfg_data[THR_W-1:0];
				REG_TICK_PERIOD: tick_period_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.long_thr    = long_thr_q;
	assign cfg.double_thr  = double_thr_q;
	assign cfg.tick_period = tick_period_q;

endmodule

[design/bced_core.sv]
// Click classifier: stage register, hold and gap counters, event decode.
// Depends on bced_pkg for the stage type, event codes and cfg_t.
module bced_core import bced_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            pressed,
	input  cfg_t            cfg,
	output logic [EV_W-1:0] event_nxt
);

	stage_t           stage_q, stage_nxt;
	logic [CNT_W-1:0] hold_q, hold_nxt;
	logic [CNT_W-1:0] gap_q, gap_nxt;
	logic [CNT_W:0]   hold_sum, gap_sum;
	logic [CNT_W-1:0] hold_sat, gap_sat;

	// Saturating advance of both counters by the tick period.
	assign hold_sum = {1'b0, hold_q} + {{(CNT_W+1-TICK_W){1'b0}}, cfg.tick_period};
	assign gap_sum  = {1'b0, gap_q} + {{(CNT_W+1-TICK_W){1'b0}}, cfg.tick_period};
	assign hold_sat = hold_sum[CNT_W] ? CNT_MAX : hold_sum[CNT_W-1:0];
	assign gap_sat  = gap_sum[CNT_W] ? CNT_MAX : gap_sum[CNT_W-1:0];

	// Next stage, counters and event for the current tick.
	always_comb begin
		stage_nxt = stage_q;
		hold_nxt  = hold_q;
		gap_nxt   = gap_q;
		event_nxt = EV_NONE;
		case (stage_q)
			ST_WAIT: begin
				if (pressed) stage_nxt = ST_DEBOUNCE;
			end
			ST_DEBOUNCE: begin
				if (pressed) begin
					stage_nxt = ST_HOLD;
					hold_nxt  = '0;
				end else begin
					stage_nxt = ST_WAIT;
				end
			end
			ST_HOLD, ST_REPEAT: begin
				if (!pressed) begin
					// A release after a long press ends without a click.
					stage_nxt = (stage_q == ST_HOLD) ? ST_GAP : ST_WAIT;
				end else if (hold_sat >= {{(CNT_W-THR_W){1'b0}}, cfg.long_thr}) begin
					event_nxt = EV_LONG;
					stage_nxt = ST_REPEAT;
					hold_nxt  = '0;
				end else begin
					hold_nxt = hold_sat;
				end
			end
			ST_GAP: begin
				gap_nxt = gap_sat;
				if (pressed) begin
					event_nxt = EV_DOUBLE;
					stage_nxt = ST_RELEASE;
				end else if (gap_sat > {{(CNT_W-THR_W){1'b0}}, cfg.double_thr}) begin
					event_nxt = EV_SINGLE;
					stage_nxt = ST_RELEASE;
				end
			end
			ST_RELEASE: begin
				if (!pressed) begin
					gap_nxt   = '0;
					hold_nxt  = '0;
					stage_nxt = ST_WAIT;
				end
			end
			default: begin
				stage_nxt = ST_WAIT;
			end
		endcase
	end

	// State advances only when a tick is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_WAIT;
			hold_q  <= '0;
			gap_q   <= '0;
		end else if (step) begin
			stage_q <= stage_nxt;
			hold_q  <= hold_nxt;
			gap_q   <= gap_nxt;
		end
	end

endmodule

[design/button_click_event_detector.sv]
// Button click event detector: each request on the input channel is one timer
// tick with the sampled button level, and each tick yields exactly one event
// code (none, single press, double click or long press). A tick passes through
// an input register, the classifier logic and a result register, and one tick
// is taken every cycle; the only limit on rate is the consumer's ready.
// Thresholds and tick period are to be written through the configuration port
// while no tick is in flight; the block itself does not enforce this.
// Depends on bced_pkg, bced_cfg and bced_core.
module button_click_event_detector import bced_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  pin_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [EV_W-1:0]       event_code,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t            cfg;
	logic            valid_s1, pin_s1;
	logic            valid_s2;
	logic [EV_W-1:0] event_s2;
	logic [EV_W-1:0] event_nxt;
	logic            adv_s2, adv_s1;

	// The result register frees when empty or taken; the input register
	// frees when empty or moving into the result register.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	bced_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bced_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.pressed   (pin_s1),
		.cfg       (cfg),
		.event_nxt (event_nxt)
	);

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
		end
	end

	// Result stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_s2 <= event_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = event_s2;

endmodule
